>>> design/fsr_pkg.sv
// Shared widths, payload structs and helpers of the fraction sum reducer.
package fsr_pkg;

   localparam int WORD_W          = 32;
   localparam int DEN_W           = 31;
   localparam int WIDE_W          = 64;
   localparam int SHIFT_W         = 6;
   localparam int VALUE_WIDTH_DEF = 32;

   typedef struct packed {
      logic [WORD_W-1:0] acc_mag;
      logic              acc_neg;
      logic [WORD_W-1:0] acc_den;
      logic [WORD_W-1:0] x_mag;
      logic              x_neg;
      logic [WORD_W-1:0] d_mag;
      logic              d_neg;
   } op_type;

   typedef struct packed {
      logic [WIDE_W-1:0] mag;
      logic [WIDE_W-1:0] den;
      logic              neg;
   } sum_type;

   typedef struct packed {
      logic [WIDE_W-1:0] sum;
      logic              borrow;
   } alu_out_type;

   function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] value);
      return value[WORD_W-1] ? (~value + 1'b1) : value;
   endfunction

endpackage

>>> design/fsr_if.sv
// Request and response channel interfaces of the fraction sum reducer.
interface fsr_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [fsr_pkg::WORD_W-1:0]   numerator;
   logic signed [fsr_pkg::WORD_W-1:0]   denominator;
   logic                                last;

   modport source (output valid, output numerator, output denominator, output last,
                   input ready);
   modport sink   (input valid, input numerator, input denominator, input last,
                   output ready);
endinterface

interface fsr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fsr_pkg::WORD_W-1:0]   sum_numerator;
   logic        [fsr_pkg::DEN_W-1:0]    sum_denominator;
   logic                                overflow;
   logic                                bad_input;

   modport source (output valid, output sum_numerator, output sum_denominator,
                   output overflow, output bad_input, input ready);
   modport sink   (input valid, input sum_numerator, input sum_denominator,
                   input overflow, input bad_input, output ready);
endinterface

>>> design/fsr_alu.sv
// Shared 64-bit add/subtract unit with borrow out.
module fsr_alu (
   input  logic [fsr_pkg::WIDE_W-1:0] a,
   input  logic [fsr_pkg::WIDE_W-1:0] b,
   input  logic                       sub,
   output fsr_pkg::alu_out_type       res
);
   localparam int SumW = fsr_pkg::WIDE_W + 1;

   logic [SumW-1:0] total;

   assign total      = {1'b0, a} + {1'b0, (sub ? ~b : b)} + SumW'(sub);
   assign res.sum    = total[SumW-2:0];
   assign res.borrow = sub & ~total[SumW-1];
endmodule

>>> design/fsr_mult.sv
// Registered 32 by 32 unsigned multiplier.
module fsr_mult (
   input  logic                       clock,
   input  logic [fsr_pkg::WORD_W-1:0] a,
   input  logic [fsr_pkg::WORD_W-1:0] b,
   output logic [fsr_pkg::WIDE_W-1:0] prod_ff
);
   logic [fsr_pkg::WIDE_W-1:0] prod_in;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

>>> design/fsr_core.sv
// Sequencer for cross multiply, signed add, binary GCD and restoring divides.
module fsr_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  fsr_pkg::op_type     op,
   output logic                done,
   output fsr_pkg::sum_type    res
);
   localparam int WideW  = fsr_pkg::WIDE_W;
   localparam int ShiftW = fsr_pkg::SHIFT_W;

   typedef enum logic [3:0] {
      C_IDLE, C_MUL_AD, C_MUL_BX, C_MUL_BD, C_ADD, C_NEGATE, C_INIT, C_GCD,
      C_DIV_NUM, C_DIV_DEN, C_DONE
   } c_state_type;

   c_state_type            state_ff, state_in;
   fsr_pkg::op_type        op_ff, op_in;
   logic [WideW-1:0]       u_ff, u_in;
   logic [WideW-1:0]       v_ff, v_in;
   logic [WideW-1:0]       mag_ff, mag_in;
   logic [WideW-1:0]       den_ff, den_in;
   logic                   neg_ff, neg_in;
   logic [ShiftW-1:0]      k_ff, k_in;
   logic [WideW-1:0]       q_ff, q_in;
   logic [WideW-1:0]       r_ff, r_in;
   logic [ShiftW-1:0]      cnt_ff, cnt_in;

   logic [fsr_pkg::WORD_W-1:0] mul_a, mul_b;
   logic [WideW-1:0]           prod;
   logic [WideW-1:0]           alu_a, alu_b;
   logic                       alu_sub;
   fsr_pkg::alu_out_type       alu;
   logic [WideW-1:0]           rem_sh, q_step;
   logic                       sign_a, sign_b;

   fsr_mult u_mult (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod)
   );

   fsr_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .res (alu)
   );

   assign sign_a = op_ff.acc_neg ^ op_ff.d_neg;
   assign sign_b = op_ff.x_neg;
   assign rem_sh = {r_ff[WideW-2:0], q_ff[WideW-1]};
   assign q_step = {q_ff[WideW-2:0], ~alu.borrow};

   assign done    = (state_ff == C_DONE);
   assign res.mag = mag_ff;
   assign res.den = den_ff;
   assign res.neg = neg_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      mag_in   = mag_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      k_in     = k_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      cnt_in   = cnt_ff;
      mul_a    = op_ff.acc_mag;
      mul_b    = op_ff.d_mag;
      alu_a    = u_ff;
      alu_b    = v_ff;
      alu_sub  = 1'b1;

      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               op_in    = op;
               state_in = C_MUL_AD;
            end
         end
         C_MUL_AD: begin
            state_in = C_MUL_BX;
         end
         C_MUL_BX: begin
            mul_a    = op_ff.acc_den;
            mul_b    = op_ff.x_mag;
            u_in     = prod;
            state_in = C_MUL_BD;
         end
         C_MUL_BD: begin
            mul_a    = op_ff.acc_den;
            mul_b    = op_ff.d_mag;
            v_in     = prod;
            state_in = C_ADD;
         end
         C_ADD: begin
            den_in  = prod;
            alu_sub = sign_a ^ sign_b;
            mag_in  = alu.sum;
            if (alu.borrow) begin
               neg_in   = sign_b ^ op_ff.d_neg;
               state_in = C_NEGATE;
            end else begin
               neg_in   = sign_a ^ op_ff.d_neg;
               state_in = C_INIT;
            end
         end
         C_NEGATE: begin
            alu_a    = '0;
            alu_b    = mag_ff;
            mag_in   = alu.sum;
            state_in = C_INIT;
         end
         C_INIT: begin
            u_in = mag_ff;
            v_in = den_ff;
            k_in = '0;
            if (mag_ff == '0) begin
               neg_in = 1'b0;
            end
            state_in = C_GCD;
         end
         C_GCD: begin
            if (u_ff == '0) begin
               q_in     = mag_ff >> k_ff;
               r_in     = '0;
               cnt_in   = '0;
               state_in = C_DIV_NUM;
            end else begin
               case ({u_ff[0], v_ff[0]})
                  2'b00: begin
                     u_in = u_ff >> 1;
                     v_in = v_ff >> 1;
                     k_in = k_ff + 1'b1;
                  end
                  2'b01: begin
                     u_in = u_ff >> 1;
                  end
                  2'b10: begin
                     v_in = v_ff >> 1;
                  end
                  default: begin
                     if (alu.borrow) begin
                        u_in = v_ff;
                        v_in = u_ff;
                     end else begin
                        u_in = alu.sum >> 1;
                     end
                  end
               endcase
            end
         end
         C_DIV_NUM: begin
            alu_a  = rem_sh;
            alu_b  = v_ff;
            r_in   = alu.borrow ? rem_sh : alu.sum;
            q_in   = q_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               mag_in   = q_step;
               q_in     = den_ff >> k_ff;
               r_in     = '0;
               state_in = C_DIV_DEN;
            end
         end
         C_DIV_DEN: begin
            alu_a  = rem_sh;
            alu_b  = v_ff;
            r_in   = alu.borrow ? rem_sh : alu.sum;
            q_in   = q_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               den_in   = q_step;
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      mag_ff <= mag_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      k_ff   <= k_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end
endmodule

>>> design/fraction_sum_reducer_unit.sv
// Top level: running sum of signed fractions kept in lowest terms.
//
//  channel   dir  beat                                                 when
//  req_bus   in   numerator, denominator, last                         valid && ready
//  rsp_bus   out  sum_numerator, sum_denominator, overflow, bad_input  valid && ready
//
// A beat with a zero denominator skips the core. Any other beat passes through the
// accept, three multiplies and the add, one setup step, the binary GCD steps, two
// restoring divides and a done state; the add, GCD and divides all use the one
// shared 64-bit subtractor. A negate step follows when the difference must be
// negated back to a magnitude; a last beat adds an emit step to load the response
// register. Reset clears the running sum to 0/1 and both flags.
// A finished sum waits in the response register; a new beat is taken meanwhile,
// and only a second finished sum holds while the first is still stalled.
module fraction_sum_reducer_unit #(
   parameter int VALUE_WIDTH = fsr_pkg::VALUE_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fsr_req_if.sink    req_bus,
   fsr_rsp_if.source  rsp_bus
);
   localparam int WordW = fsr_pkg::WORD_W;
   localparam int DenW  = fsr_pkg::DEN_W;
   localparam int WideW = fsr_pkg::WIDE_W;
   localparam logic [WideW-1:0] Lim = WideW'(1) << (VALUE_WIDTH - 1);

   typedef enum logic [1:0] {T_IDLE, T_CALC, T_EMIT} t_state_type;

   t_state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   acc_num_ff, acc_num_in;
   logic [VALUE_WIDTH-2:0]   acc_den_ff, acc_den_in;
   logic                     ovf_ff, ovf_in;
   logic                     bad_ff, bad_in;
   logic                     last_ff, last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WordW-1:0]         rsp_num_ff, rsp_num_in;
   logic [DenW-1:0]          rsp_den_ff, rsp_den_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;
   logic                     rsp_bad_ff, rsp_bad_in;

   logic                     accept;
   logic                     core_start;
   logic                     core_done;
   logic                     ovf_hit;
   logic [VALUE_WIDTH-1:0]   acc_mag;
   fsr_pkg::op_type          op;
   fsr_pkg::sum_type         res;

   fsr_core u_core (
      .clock (clock),
      .reset (reset),
      .start (core_start),
      .op    (op),
      .done  (core_done),
      .res   (res)
   );

   assign req_bus.ready           = (state_ff == T_IDLE);
   assign accept                  = req_bus.valid & req_bus.ready;
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.sum_numerator   = rsp_num_ff;
   assign rsp_bus.sum_denominator = rsp_den_ff;
   assign rsp_bus.overflow        = rsp_ovf_ff;
   assign rsp_bus.bad_input       = rsp_bad_ff;

   assign acc_mag    = acc_num_ff[VALUE_WIDTH-1] ? (~acc_num_ff + 1'b1) : acc_num_ff;
   assign op.acc_mag = WordW'(acc_mag);
   assign op.acc_neg = acc_num_ff[VALUE_WIDTH-1];
   assign op.acc_den = WordW'(acc_den_ff);
   assign op.x_mag   = fsr_pkg::magnitude(req_bus.numerator);
   assign op.x_neg   = req_bus.numerator[WordW-1];
   assign op.d_mag   = fsr_pkg::magnitude(req_bus.denominator);
   assign op.d_neg   = req_bus.denominator[WordW-1];

   assign ovf_hit = (res.den > (Lim - 1'b1)) ||
                    (res.neg ? (res.mag > Lim) : (res.mag > (Lim - 1'b1)));

   always_comb begin
      state_in     = state_ff;
      acc_num_in   = acc_num_ff;
      acc_den_in   = acc_den_ff;
      ovf_in       = ovf_ff;
      bad_in       = bad_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_bad_in   = rsp_bad_ff;
      core_start   = 1'b0;

      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               last_in = req_bus.last;
               if (req_bus.denominator == '0) begin
                  bad_in = 1'b1;
                  if (req_bus.last) begin
                     state_in = T_EMIT;
                  end
               end else begin
                  core_start = 1'b1;
                  state_in   = T_CALC;
               end
            end
         end
         T_CALC: begin
            if (core_done) begin
               if (ovf_hit) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_num_in = res.neg ? (~res.mag[VALUE_WIDTH-1:0] + 1'b1)
                                       : res.mag[VALUE_WIDTH-1:0];
                  acc_den_in = res.den[VALUE_WIDTH-2:0];
               end
               state_in = last_ff ? T_EMIT : T_IDLE;
            end
         end
         T_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = WordW'($signed(acc_num_ff));
               rsp_den_in   = DenW'(acc_den_ff);
               rsp_ovf_in   = ovf_ff;
               rsp_bad_in   = bad_ff;
               acc_num_in   = '0;
               acc_den_in   = (VALUE_WIDTH-1)'(1);
               ovf_in       = 1'b0;
               bad_in       = 1'b0;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         acc_num_ff   <= '0;
         acc_den_ff   <= (VALUE_WIDTH-1)'(1);
         ovf_ff       <= 1'b0;
         bad_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_num_ff   <= acc_num_in;
         acc_den_ff   <= acc_den_in;
         ovf_ff       <= ovf_in;
         bad_ff       <= bad_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_bad_ff <= rsp_bad_in;
   end
endmodule
